[sv/u8dtv_pkg.sv]
package u8dtv_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MAXL_W  = 16;
    localparam int unsigned COUNT_W = 17;

    localparam logic [MAXL_W-1:0] MAX_LEN_RESET = 16'd1024;

    localparam logic [BYTE_W-1:0] B_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] B_DEL      = 8'h7f;
    localparam logic [BYTE_W-1:0] B_CONT_LO  = 8'h80;
    localparam logic [BYTE_W-1:0] B_C2       = 8'hc2;
    localparam logic [BYTE_W-1:0] B_DF       = 8'hdf;
    localparam logic [BYTE_W-1:0] B_E0       = 8'he0;
    localparam logic [BYTE_W-1:0] B_ED       = 8'hed;
    localparam logic [BYTE_W-1:0] B_EF       = 8'hef;
    localparam logic [BYTE_W-1:0] B_F0       = 8'hf0;
    localparam logic [BYTE_W-1:0] B_F4       = 8'hf4;
    localparam logic [BYTE_W-1:0] B_8F       = 8'h8f;
    localparam logic [BYTE_W-1:0] B_90       = 8'h90;
    localparam logic [BYTE_W-1:0] B_9F       = 8'h9f;
    localparam logic [BYTE_W-1:0] B_A0       = 8'ha0;
    localparam logic [BYTE_W-1:0] B_BF       = 8'hbf;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_TOO_LONG = 2'd1,
        VERDICT_CONTROL  = 2'd2,
        VERDICT_BAD_UTF8 = 2'd3
    } verdict_t;

    // allowed range for the next continuation byte
    typedef enum logic [2:0] {
        CLS_ANY = 3'd0,
        CLS_E0  = 3'd1,
        CLS_ED  = 3'd2,
        CLS_F0  = 3'd3,
        CLS_F4  = 3'd4,
        CLS_C2  = 3'd5
    } byte_class_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              has_byte;
        logic              last;
    } item_t;

endpackage

[sv/u8dtv_if.sv]
interface u8dtv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output text_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input text_byte, input has_byte, input last,
                    output ready);
endinterface

interface u8dtv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [16:0] byte_count;

    modport source (output valid, output verdict, output byte_count, input ready);
    modport sink   (input valid, input verdict, input byte_count, output ready);
endinterface

interface u8dtv_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_text_length;

    modport source (output valid, output max_text_length, input ready);
    modport sink   (input valid, input max_text_length, output ready);
endinterface

[sv/u8dtv_in_stage.sv]
module u8dtv_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    u8dtv_in_if.sink             text_in,
    output logic                 item_valid,
    output u8dtv_pkg::item_t     item,
    input  logic                 item_take
);
    import u8dtv_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign text_in.ready = !valid_reg || item_take;
    assign load          = text_in.valid && text_in.ready;
    assign valid_next    = load ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.text_byte <= text_in.text_byte;
            item_reg.has_byte  <= text_in.has_byte;
            item_reg.last      <= text_in.last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/u8dtv_decoder.sv]
module u8dtv_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  u8dtv_pkg::item_t                  item,
    output logic                              item_take,
    input  logic [u8dtv_pkg::MAXL_W-1:0]      max_len,
    u8dtv_out_if.source                       result_out
);
    import u8dtv_pkg::*;

    logic [1:0]         pend_reg, pend_next;
    byte_class_t        cls_reg, cls_next;
    verdict_t           err_reg, err_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    verdict_t           verdict_reg, verdict_next;
    logic [COUNT_W-1:0] count_out_reg;

    logic               out_free;
    logic               fire;
    logic               emit;
    logic [1:0]         pend_dec;
    byte_class_t        cls_dec;
    verdict_t           err_dec;
    logic [BYTE_W-1:0]  lo;
    logic [BYTE_W-1:0]  hi;
    logic [BYTE_W-1:0]  b;

    assign out_free  = !out_valid_reg || result_out.ready;
    assign item_take = item_valid && (!item.last || out_free);
    assign fire      = item_take;
    assign emit      = fire && item.last;
    assign b         = item.text_byte;

    // continuation range for the current class
    always_comb
    begin
        lo = B_CONT_LO;
        hi = B_BF;
        case (cls_reg)
            CLS_E0:  lo = B_A0;
            CLS_ED:  hi = B_9F;
            CLS_F0:  lo = B_90;
            CLS_F4:  hi = B_8F;
            default: ;
        endcase
    end

    // one byte through the decoder, valid when no error is latched
    always_comb
    begin
        pend_dec = pend_reg;
        cls_dec  = cls_reg;
        err_dec  = err_reg;
        if (pend_reg != 2'd0)
        begin
            if (b < lo || b > hi)
            begin
                err_dec = VERDICT_BAD_UTF8;
            end
            else if (cls_reg == CLS_C2 && b <= B_9F)
            begin
                err_dec = VERDICT_CONTROL;
            end
            else
            begin
                cls_dec  = CLS_ANY;
                pend_dec = pend_reg - 2'd1;
            end
        end
        else if (b <= B_DEL)
        begin
            if (b < B_SPACE || b == B_DEL)
            begin
                err_dec = VERDICT_CONTROL;
            end
        end
        else if (b >= B_C2 && b <= B_DF)
        begin
            pend_dec = 2'd1;
            cls_dec  = (b == B_C2) ? CLS_C2 : CLS_ANY;
        end
        else if (b >= B_E0 && b <= B_EF)
        begin
            pend_dec = 2'd2;
            cls_dec  = (b == B_E0) ? CLS_E0 : ((b == B_ED) ? CLS_ED : CLS_ANY);
        end
        else if (b >= B_F0 && b <= B_F4)
        begin
            pend_dec = 2'd3;
            cls_dec  = (b == B_F0) ? CLS_F0 : ((b == B_F4) ? CLS_F4 : CLS_ANY);
        end
        else
        begin
            err_dec = VERDICT_BAD_UTF8;
        end
    end

    always_comb
    begin
        pend_next    = pend_reg;
        cls_next     = cls_reg;
        err_next     = err_reg;
        cnt_next     = cnt_reg;
        verdict_next = verdict_reg;
        if (fire && item.has_byte)
        begin
            // top bit set means the count has saturated
            if (!cnt_reg[COUNT_W-1])
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (err_reg == VERDICT_OK)
            begin
                pend_next = pend_dec;
                cls_next  = cls_dec;
                err_next  = err_dec;
            end
        end
        if (cnt_next > {1'b0, max_len})
        begin
            verdict_next = VERDICT_TOO_LONG;
        end
        else if (err_next != VERDICT_OK)
        begin
            verdict_next = err_next;
        end
        else if (pend_next != 2'd0)
        begin
            verdict_next = VERDICT_BAD_UTF8;
        end
        else
        begin
            verdict_next = VERDICT_OK;
        end
        if (!emit)
        begin
            verdict_next = verdict_reg;
        end
    end

    assign out_valid_next = emit ? 1'b1 : (result_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 2'd0;
            cls_reg       <= CLS_ANY;
            err_reg       <= VERDICT_OK;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                pend_reg <= 2'd0;
                cls_reg  <= CLS_ANY;
                err_reg  <= VERDICT_OK;
                cnt_reg  <= '0;
            end
            else
            begin
                pend_reg <= pend_next;
                cls_reg  <= cls_next;
                err_reg  <= err_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            count_out_reg <= cnt_next;
        end
        verdict_reg <= verdict_next;
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.verdict    = verdict_reg;
    assign result_out.byte_count = count_out_reg;

endmodule

[sv/utf8_display_text_validator.sv]
// Checks one display text, one byte per item, for strict UTF-8 without
// control characters (C0, DEL, C1 as C2 80..9F) and gives one verdict with
// the saturating byte count on the item marked last. Every item is
// registered at the input, then the decoder state and the result register
// update when the decoder takes it, so items stream at one per cycle
// unless a last item stalls. An input item is still taken while a verdict
// waits at the output; only a last item stalls until the result register
// is free. A length over max_text_length wins over content errors. The
// max_text_length register is always ready and is to be written only while
// no text is in flight.
module utf8_display_text_validator (
    input  logic        clk,
    input  logic        rst_n,
    u8dtv_in_if.sink    text_in,
    u8dtv_out_if.source result_out,
    u8dtv_cfg_if.sink   cfg
);
    import u8dtv_pkg::*;

    logic [MAXL_W-1:0] max_len_reg;
    logic [MAXL_W-1:0] max_len_next;
    logic              item_valid;
    item_t             item;
    logic              item_take;

    assign cfg.ready    = 1'b1;
    assign max_len_next = (cfg.valid && cfg.ready) ? cfg.max_text_length : max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    u8dtv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    u8dtv_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .max_len    (max_len_reg),
        .result_out (result_out)
    );

endmodule
